// ===== src/rgbpw_pkg.sv =====
// shared types, constants and helpers for the rgb pulse width color reader
package rgbpw_pkg;

	localparam int COUNTER_WIDTH = 16;
	localparam int CNT_W         = 15;
	localparam int PRE_W         = 11;
	localparam int PRE_CNT_W     = 10;
	localparam int IN_TDATA_W    = 8;
	localparam int OUT_TDATA_W   = 56;

	localparam logic [PRE_W-1:0] DIV_MIN   = 11'd1;
	localparam logic [PRE_W-1:0] DIV_MAX   = 11'd1024;
	localparam logic [PRE_W-1:0] DIV_RESET = 11'd8;
	localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7fff;

	// filter sequence index, also the slot of the stored count
	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;

	// dominant color codes
	localparam logic [1:0] DOM_RED   = 2'd0;
	localparam logic [1:0] DOM_BLUE  = 2'd1;
	localparam logic [1:0] DOM_GREEN = 2'd2;
	localparam logic [1:0] DOM_NONE  = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_LOW,
		PH_WAIT_HIGH,
		PH_COUNT
	} phase_t;

	// one result beat, scale_s0 in the lowest bit
	typedef struct packed {
		logic [1:0]       dominant;
		logic [CNT_W-1:0] blue_count;
		logic [CNT_W-1:0] green_count;
		logic [CNT_W-1:0] red_count;
		logic             done_res;
		logic             busy_res;
		logic             filter_s3;
		logic             filter_s2;
		logic             scale_s1;
		logic             scale_s0;
	} result_t;

	function automatic logic [1:0] pick_dominant(
		input logic [CNT_W-1:0] r,
		input logic [CNT_W-1:0] g,
		input logic [CNT_W-1:0] b
	);
		logic [1:0] d;
		if (r < b && r < g)
			d = DOM_RED;
		else if (b < r && b < g)
			d = DOM_BLUE;
		else if (g < b && g < r)
			d = DOM_GREEN;
		else
			d = DOM_NONE;
		return d;
	endfunction

	function automatic logic [PRE_W-1:0] clamp_div(input logic [PRE_W-1:0] v);
		logic [PRE_W-1:0] d;
		if (v < DIV_MIN)
			d = DIV_MIN;
		else if (v > DIV_MAX)
			d = DIV_MAX;
		else
			d = v;
		return d;
	endfunction

endpackage

// ===== src/rgb_pulse_width_color_reader_core.sv =====
// top level: stream ports, input stage, result register and prescale register
// path: an input beat is registered in the input stage, then in the result register that drives the output
// throughput: one input beat per cycle while the output is free or taken, one result beat for every input beat
// the input stage and result register both move while the output is free or taken
// reset: asynchronous active low; idle, red selected, counts zero, dominant none,
// prescale divider 8, no beat held in either stage
module rgb_pulse_width_color_reader_core
	import rgbpw_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] sensor_level, [1] start_req, rest zero
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [0] scale_s0, [1] scale_s1, [2] filter_s2,
	                                              // [3] filter_s3, [4] busy_res, [5] done_res,
	                                              // [20:6] red_count, [35:21] green_count,
	                                              // [50:36] blue_count, [52:51] dominant
	// prescale divider register write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [PRE_W-1:0]       cfg_data
);

	logic             valid_s1;
	logic             level_s1;
	logic             start_s1;
	logic             out_valid_q;
	result_t          res_q;
	result_t          res_d;
	logic [PRE_W-1:0] prescale_q;
	logic             out_free;
	logic             adv;
	logic             in_beat;

	// config is always taken; the stored divider is already clamped to 1..1024
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prescale_q <= DIV_RESET;
		else if (cfg_valid)
			prescale_q <= clamp_div(cfg_data);
	end

	// handshake: stage 1 moves on when the result register is empty or being drained
	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (out_free)
				out_valid_q <= adv;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			level_s1 <= s_axis_tdata[0];
			start_s1 <= s_axis_tdata[1];
		end
	end

	// sequencer state advances once per input beat as it enters the result register
	rgbpw_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.level    (level_s1),
		.start    (start_s1),
		.prescale (prescale_q),
		.res_d    (res_d)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), res_q};

endmodule

// ===== src/rgbpw_fsm.sv =====
// read sequencer: phase, prescaler, pulse counter, stored counts and result logic
module rgbpw_fsm
	import rgbpw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             level,
	input  logic             start,
	input  logic [PRE_W-1:0] prescale,
	output result_t          res_d
);

	localparam int HALF_EXT_W = 33;

	phase_t                   phase_q, phase_d;
	logic [1:0]               color_q, color_d;
	logic [PRE_CNT_W-1:0]     pre_q, pre_d;
	logic [COUNTER_WIDTH-1:0] pulse_q, pulse_d;
	logic [CNT_W-1:0]         counts_q [3];
	logic [CNT_W-1:0]         counts_d [3];
	logic [1:0]               dom_q, dom_d;
	logic                     done;

	logic [PRE_W-1:0]         pre_inc;
	logic [1:0]               ci;
	logic [HALF_EXT_W-1:0]    half_ext;
	logic [CNT_W-1:0]         half_sat;
	logic                     busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			color_q     <= COLOR_RED;
			pre_q       <= '0;
			pulse_q     <= '0;
			counts_q[0] <= '0;
			counts_q[1] <= '0;
			counts_q[2] <= '0;
			dom_q       <= DOM_NONE;
		end else if (step) begin
			phase_q     <= phase_d;
			color_q     <= color_d;
			pre_q       <= pre_d;
			pulse_q     <= pulse_d;
			counts_q[0] <= counts_d[0];
			counts_q[1] <= counts_d[1];
			counts_q[2] <= counts_d[2];
			dom_q       <= dom_d;
		end
	end

	assign pre_inc  = {1'b0, pre_q} + PRE_W'(1);
	assign ci       = (color_q > COLOR_BLUE) ? COLOR_BLUE : color_q;
	assign half_ext = {{(HALF_EXT_W-COUNTER_WIDTH){1'b0}}, pulse_q} >> 1;
	assign half_sat = (half_ext > HALF_EXT_W'(COUNT_MAX)) ? COUNT_MAX : half_ext[CNT_W-1:0];

	always_comb begin
		phase_d     = phase_q;
		color_d     = color_q;
		pre_d       = pre_q;
		pulse_d     = pulse_q;
		counts_d[0] = counts_q[0];
		counts_d[1] = counts_q[1];
		counts_d[2] = counts_q[2];
		dom_d       = dom_q;
		done        = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start) begin
					color_d = COLOR_RED;
					phase_d = PH_WAIT_LOW;
				end
			end
			PH_WAIT_LOW: begin
				if (!level)
					phase_d = PH_WAIT_HIGH;
			end
			PH_WAIT_HIGH: begin
				if (level) begin
					pre_d   = '0;
					pulse_d = '0;
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (level) begin
					if (pre_inc >= prescale) begin
						pre_d = '0;
						if (pulse_q != '1)
							pulse_d = pulse_q + COUNTER_WIDTH'(1);
					end else begin
						pre_d = pre_inc[PRE_CNT_W-1:0];
					end
				end else begin
					counts_d[ci] = half_sat;
					if (ci == COLOR_BLUE) begin
						dom_d   = pick_dominant(counts_d[0], counts_d[1], counts_d[2]);
						done    = 1'b1;
						color_d = COLOR_RED;
						phase_d = PH_IDLE;
					end else begin
						color_d = ci + 2'd1;
						phase_d = PH_WAIT_LOW;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// result shows the state after this tick
	assign busy = (phase_d != PH_IDLE);

	always_comb begin
		res_d.scale_s0    = busy;
		res_d.scale_s1    = 1'b0;
		res_d.filter_s2   = busy && (color_d == COLOR_GREEN);
		res_d.filter_s3   = busy && (color_d == COLOR_GREEN || color_d == COLOR_BLUE);
		res_d.busy_res    = busy;
		res_d.done_res    = done;
		res_d.red_count   = counts_d[0];
		res_d.green_count = counts_d[1];
		res_d.blue_count  = counts_d[2];
		res_d.dominant    = dom_d;
	end

endmodule

// ===== src/rgbpw_checker.sv =====
// port level checks for the color reader, bound to the top level
module rgbpw_checker
	import rgbpw_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// done is never shown together with busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[4])
		else $error("done shown while busy");

	// scale select 0 follows busy, select 1 stays low
	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == m_axis_tdata[4]) && !m_axis_tdata[1])
		else $error("scale selects wrong");

	// filter selects are low when idle, and s2 never high without s3
	a_filter: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (!m_axis_tdata[4] || m_axis_tdata[2]) |-> 
			(m_axis_tdata[4] ? m_axis_tdata[3] : !m_axis_tdata[2] && !m_axis_tdata[3]))
		else $error("filter selects wrong");

endmodule

bind rgb_pulse_width_color_reader_core rgbpw_checker u_rgbpw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
